// ===== hw/rtl/dsp_pkg.sv =====
`timescale 1ns / 1ps

package dsp_pkg;

   // fixed field widths
   localparam int NODE_W      = 3;
   localparam int WEIGHT_W    = 16;
   localparam int DIST_W      = 20;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // request tdata: from(3) to(3) weight(16) edge_valid(1) pad(1)
   localparam int REQ_TDATA_W = 24;
   // result tdata: path_node(3) reachable(1) total_distance(20)
   localparam int RSP_TDATA_W = 24;

   localparam int REV_DEPTH   = 8;
   localparam int REV_W       = $clog2(REV_DEPTH);

   localparam int NODES_DEF       = 8;
   localparam int WEIGHT_BITS_DEF = 16;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_RELAX,
      ST_WALK_RD,
      ST_WALK_STEP,
      ST_EMIT,
      ST_MISS
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0] sum;
      logic              lt;
   } alu_res_type;

endpackage

// ===== hw/rtl/dsp_alu.sv =====
`timescale 1ns / 1ps

// saturating add, then strict less-than against a third operand
module dsp_alu (
   input  logic [dsp_pkg::DIST_W-1:0] a,
   input  logic [dsp_pkg::DIST_W-1:0] b,
   input  logic [dsp_pkg::DIST_W-1:0] c,
   output dsp_pkg::alu_res_type       res
);
   import dsp_pkg::*;

   logic [DIST_W:0] raw;

   always_comb begin
      raw = {1'b0, a} + {1'b0, b};
      res.sum = raw[DIST_W] ? DIST_MAX : raw[DIST_W-1:0];
      res.lt  = (res.sum < c);
   end

endmodule

// ===== hw/rtl/dsp_edge_mem.sv =====
`timescale 1ns / 1ps

// edge store: {exists, length} per (source, target); swept clear after reset
module dsp_edge_mem #(
   parameter int NODE_BITS = 3,
   parameter int LEN_W     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [2*NODE_BITS-1:0] wr_addr,
   input  logic                   wr_exists,
   input  logic [LEN_W-1:0]       wr_len,
   input  logic                   rd_en,
   input  logic [2*NODE_BITS-1:0] rd_addr,
   output logic                   rd_exists,
   output logic [LEN_W-1:0]       rd_len,
   output logic                   busy
);
   import dsp_pkg::*;

   localparam int EA_W  = 2 * NODE_BITS;
   localparam int DEPTH = 1 << EA_W;

   logic [LEN_W:0]  edge_ram_ff [DEPTH];
   logic [LEN_W:0]  rd_q_ff;
   logic            clr_ff, clr_in;
   logic [EA_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {EA_W{1'b1}}) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         edge_ram_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         edge_ram_ff[wr_addr] <= {wr_exists, wr_len};
      end
      if (rd_en) begin
         rd_q_ff <= edge_ram_ff[rd_addr];
      end
   end

   assign rd_exists = rd_q_ff[LEN_W];
   assign rd_len    = rd_q_ff[LEN_W-1:0];
   assign busy      = clr_ff;

endmodule

// ===== hw/rtl/dsp_node_mem.sv =====
`timescale 1ns / 1ps

// per-node distance and predecessor, one write and one read port
module dsp_node_mem #(
   parameter int NODES     = 8,
   parameter int NODE_BITS = 3
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [NODE_BITS-1:0]       wr_addr,
   input  logic [dsp_pkg::DIST_W-1:0] wr_dist,
   input  logic [NODE_BITS-1:0]       wr_pred,
   input  logic                       rd_en,
   input  logic [NODE_BITS-1:0]       rd_addr,
   output logic [dsp_pkg::DIST_W-1:0] rd_dist,
   output logic [NODE_BITS-1:0]       rd_pred
);
   import dsp_pkg::*;

   logic [DIST_W-1:0]    dist_ram_ff [NODES];
   logic [NODE_BITS-1:0] pred_ram_ff [NODES];
   logic [DIST_W-1:0]    rd_dist_ff;
   logic [NODE_BITS-1:0] rd_pred_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_ram_ff[wr_addr] <= wr_dist;
         pred_ram_ff[wr_addr] <= wr_pred;
      end
      if (rd_en) begin
         rd_dist_ff <= dist_ram_ff[rd_addr];
         rd_pred_ff <= pred_ram_ff[rd_addr];
      end
   end

   assign rd_dist = rd_dist_ff;
   assign rd_pred = rd_pred_ff;

endmodule

// ===== hw/rtl/dijkstra_shortest_path.sv =====
`timescale 1ns / 1ps
// Edge load item: accepted with no result; loads can go back to back.
// Query item: an init step, then per settled node a scan over all nodes and a
//   relax pass over all nodes, a final scan, a read and a step per path node,
//   then one result per cycle as taken; the next item is accepted only after
//   the last result of the query is taken.
// Reset (sync, active high): edge store swept clear; requests wait for the sweep.
module dijkstra_shortest_path #(
   parameter int NODES       = dsp_pkg::NODES_DEF,
   parameter int WEIGHT_BITS = dsp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // from_node[2:0], to_node[5:3], weight[21:6], edge_valid[22], zero pad[23]
   input  logic [dsp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // path_node[2:0], reachable[3], total_distance[23:4]
   output logic [dsp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import dsp_pkg::*;

   localparam int NB    = $clog2(NODES);
   localparam int CW    = $clog2(NODES + 1);
   localparam int LEN_W = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

   // request fields
   logic [NODE_W-1:0]   req_from, req_to;
   logic [WEIGHT_W-1:0] req_weight;
   logic                req_edge_valid;
   logic                req_acc, rsp_acc, in_range;

   assign req_from       = req_tdata[2:0];
   assign req_to         = req_tdata[5:3];
   assign req_weight     = req_tdata[21:6];
   assign req_edge_valid = req_tdata[22];
   assign req_acc        = req_tvalid && req_tready;
   assign rsp_acc        = rsp_tvalid && rsp_tready;
   // only narrow graphs can see a node index past the end
   assign in_range = (32'(req_from) < 32'(NODES)) && (32'(req_to) < 32'(NODES));

   // sequencer state
   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;       // issue index of scan / relax
   logic                 pend_ff, pend_in;     // read data valid this cycle
   logic [NB-1:0]        idx_ff, idx_in;       // node whose data is back
   logic [NB-1:0]        u_ff, u_in;           // node being settled
   logic                 ufound_ff, ufound_in;
   logic [DIST_W-1:0]    bestd_ff, bestd_in;
   logic [NB-1:0]        start_ff, start_in, dest_ff, dest_in;
   logic [NODES-1:0]     reached_ff, reached_in;
   logic [NODES-1:0]     settled_ff, settled_in;
   logic [NODES-1:0]     haspred_ff, haspred_in;
   logic [NB-1:0]        at_ff, at_in;         // path walk position
   logic [CW-1:0]        len_ff, len_in;
   logic [NB-1:0]        rev_ff [REV_DEPTH];   // path, destination first
   logic [NB-1:0]        rev_in [REV_DEPTH];
   logic [REV_W-1:0]     emitm1_ff, emitm1_in, k_ff, k_in;
   logic [DIST_W-1:0]    total_ff, total_in;

   // memory and unit hookup
   logic                 ewr_en, erd_en, erd_exists, clr_busy;
   logic [2*NB-1:0]      ewr_addr, erd_addr;
   logic [LEN_W-1:0]     erd_len;
   logic                 nwr_en, nrd_en;
   logic [NB-1:0]        nwr_addr, nwr_pred, nrd_addr, nrd_pred;
   logic [DIST_W-1:0]    nwr_dist, nrd_dist;
   logic [DIST_W-1:0]    alu_a, alu_b, alu_c;
   alu_res_type          alu_res;

   logic issue, pass_end, scan_take, found, walk_stop;

   dsp_edge_mem #(
      .NODE_BITS (NB),
      .LEN_W     (LEN_W)
   ) u_edge (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (ewr_en),
      .wr_addr   (ewr_addr),
      .wr_exists (req_edge_valid),
      .wr_len    (LEN_W'(req_weight)),
      .rd_en     (erd_en),
      .rd_addr   (erd_addr),
      .rd_exists (erd_exists),
      .rd_len    (erd_len),
      .busy      (clr_busy)
   );

   dsp_node_mem #(
      .NODES     (NODES),
      .NODE_BITS (NB)
   ) u_node (
      .clock   (clock),
      .wr_en   (nwr_en),
      .wr_addr (nwr_addr),
      .wr_dist (nwr_dist),
      .wr_pred (nwr_pred),
      .rd_en   (nrd_en),
      .rd_addr (nrd_addr),
      .rd_dist (nrd_dist),
      .rd_pred (nrd_pred)
   );

   // shared unit: scan compares d[i] + 0 < best, relax compares best + len < d[v]
   assign alu_a = (state_ff == ST_RELAX) ? bestd_ff : nrd_dist;
   assign alu_b = (state_ff == ST_RELAX) ? DIST_W'(erd_len) : '0;
   assign alu_c = (state_ff == ST_RELAX) ? nrd_dist : bestd_ff;

   dsp_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .res (alu_res)
   );

   assign issue    = (cnt_ff != CW'(NODES));
   assign pass_end = !issue && pend_ff;
   // strict compare in index order: lower index keeps a tie
   assign scan_take = (state_ff == ST_SCAN) && pend_ff && reached_ff[idx_ff] &&
                      !settled_ff[idx_ff] && (!ufound_ff || alu_res.lt);
   assign found     = ufound_ff || scan_take;
   assign walk_stop = (at_ff == start_ff) || !haspred_ff[at_ff] ||
                      (len_ff == CW'(NODES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == OP_QUERY)) begin
               state_in = in_range ? ST_INIT : ST_MISS;
            end
         end
         ST_INIT: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (pass_end) begin
               if (found) begin
                  state_in = ST_RELAX;
               end else if (reached_ff[dest_ff]) begin
                  state_in = ST_WALK_RD;
               end else begin
                  state_in = ST_MISS;
               end
            end
         end
         ST_RELAX: begin
            if (pass_end) begin
               state_in = ST_SCAN;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_STEP;
         end
         ST_WALK_STEP: begin
            state_in = walk_stop ? ST_EMIT : ST_WALK_RD;
         end
         ST_EMIT: begin
            if (rsp_acc && (k_ff == emitm1_ff)) begin
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      cnt_in     = cnt_ff;
      pend_in    = pend_ff;
      idx_in     = idx_ff;
      u_in       = u_ff;
      ufound_in  = ufound_ff;
      bestd_in   = bestd_ff;
      start_in   = start_ff;
      dest_in    = dest_ff;
      reached_in = reached_ff;
      settled_in = settled_ff;
      haspred_in = haspred_ff;
      at_in      = at_ff;
      len_in     = len_ff;
      rev_in     = rev_ff;
      emitm1_in  = emitm1_ff;
      k_in       = k_ff;
      total_in   = total_ff;
      ewr_en     = 1'b0;
      ewr_addr   = {NB'(req_from), NB'(req_to)};
      erd_en     = 1'b0;
      erd_addr   = {u_ff, NB'(cnt_ff)};
      nwr_en     = 1'b0;
      nwr_addr   = idx_ff;
      nwr_dist   = alu_res.sum;
      nwr_pred   = u_ff;
      nrd_en     = 1'b0;
      nrd_addr   = NB'(cnt_ff);
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = '0;
      rsp_tlast  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !clr_busy;
            if (req_acc) begin
               start_in = NB'(req_from);
               dest_in  = NB'(req_to);
               // removal rewrites the length too; it is read only when present
               if ((req_tuser == OP_LOAD) && in_range) begin
                  ewr_en = 1'b1;
               end
            end
         end
         ST_INIT: begin
            reached_in           = '0;
            reached_in[start_ff] = 1'b1;
            settled_in           = '0;
            haspred_in           = '0;
            nwr_en               = 1'b1;
            nwr_addr             = start_ff;
            nwr_dist             = '0;
            cnt_in               = '0;
            pend_in              = 1'b0;
            ufound_in            = 1'b0;
         end
         ST_SCAN: begin
            nrd_en  = issue;
            pend_in = issue;
            idx_in  = NB'(cnt_ff);
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (scan_take) begin
               u_in      = idx_ff;
               bestd_in  = nrd_dist;
               ufound_in = 1'b1;
            end
            if (pass_end) begin
               if (found) begin
                  settled_in[u_in] = 1'b1;
                  cnt_in           = '0;
                  pend_in          = 1'b0;
               end else begin
                  // read port is free now: fetch the destination for the walk
                  nrd_en   = 1'b1;
                  nrd_addr = dest_ff;
                  at_in    = dest_ff;
                  len_in   = '0;
               end
            end
         end
         ST_RELAX: begin
            erd_en  = issue;
            nrd_en  = issue;
            pend_in = issue;
            idx_in  = NB'(cnt_ff);
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            // write lands on idx while the read goes to the next node
            if (pend_ff && erd_exists && (!reached_ff[idx_ff] || alu_res.lt)) begin
               nwr_en             = 1'b1;
               reached_in[idx_ff] = 1'b1;
               haspred_in[idx_ff] = 1'b1;
            end
            if (pass_end) begin
               cnt_in    = '0;
               pend_in   = 1'b0;
               ufound_in = 1'b0;
            end
         end
         ST_WALK_RD: begin
            nrd_en   = 1'b1;
            nrd_addr = at_ff;
         end
         ST_WALK_STEP: begin
            if (len_ff == '0) begin
               total_in = nrd_dist;
            end
            // keep only the eight nodes nearest the destination
            if (32'(len_ff) < REV_DEPTH) begin
               rev_in[REV_W'(len_ff)] = at_ff;
            end
            len_in = len_ff + 1'b1;
            if (walk_stop) begin
               emitm1_in = (32'(len_ff) >= REV_DEPTH - 1) ? REV_W'(REV_DEPTH - 1)
                                                          : REV_W'(len_ff);
               k_in      = '0;
            end else begin
               at_in = nrd_pred;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {total_ff, 1'b1, NODE_W'(rev_ff[emitm1_ff - k_ff])};
            rsp_tlast  = (k_ff == emitm1_ff);
            if (rsp_acc) begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_MISS: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = 1'b1;
         end
         default: begin
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         pend_ff    <= 1'b0;
         ufound_ff  <= 1'b0;
         reached_ff <= '0;
         settled_ff <= '0;
         haspred_ff <= '0;
         len_ff     <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pend_ff    <= pend_in;
         ufound_ff  <= ufound_in;
         reached_ff <= reached_in;
         settled_ff <= settled_in;
         haspred_ff <= haspred_in;
         len_ff     <= len_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      u_ff      <= u_in;
      bestd_ff  <= bestd_in;
      start_ff  <= start_in;
      dest_ff   <= dest_in;
      at_ff     <= at_in;
      rev_ff    <= rev_in;
      emitm1_ff <= emitm1_in;
      total_ff  <= total_in;
   end

   // a settled node was always reached first
   a_settled_reached: assert property (@(posedge clock) disable iff (reset)
      (settled_ff & ~reached_ff) == '0)
      else $error("settled node not reached");

   // relax runs only from a node marked settled
   a_relax_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> settled_ff[u_ff])
      else $error("relaxing from unsettled node");

   // never take a new item while a result is offered
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request ready during result");

   // the last result of a query frees the block
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (state_ff == ST_IDLE))
      else $error("not idle after last result");

endmodule

// ===== tb/dijkstra_shortest_path_tb.sv =====
`timescale 1ns / 1ps

module dijkstra_shortest_path_tb;
   import dsp_pkg::*;

   localparam int NODES       = NODES_DEF;
   localparam int EDGES       = NODES * NODES;
   // longest quiet stretch: reset sweep or a full query plus receiver stalls
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_WAIT = 200;

   // one emitted hop of a route
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              reach;
      logic [DIST_W-1:0] total;
      logic              last;
   } route_hop;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // from_node[2:0], to_node[5:3], weight[21:6], edge_valid[22], zero pad[23]
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // operation[0]
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // path_node[2:0], reachable[3], total_distance[23:4]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   // shadow copy of the graph
   logic [WEIGHT_W-1:0] edge_len [EDGES];
   bit                  edge_on  [EDGES];

   route_hop pending_hops[$];
   int       mismatches    = 0;
   int       items_sent    = 0;
   int       quiet_cycles  = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;

   dijkstra_shortest_path u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Dijkstra over the shadow graph; queues the hops the block must emit.
   // Lower index wins a tie on the pick, predecessor moves only on strict gain.
   task automatic predict_route(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
      logic [DIST_W-1:0] best   [NODES];
      bit                seen   [NODES];
      bit                done   [NODES];
      bit                linked [NODES];
      logic [NODE_W-1:0] via    [NODES];
      logic [NODE_W-1:0] trail  [NODES];
      logic [DIST_W:0]   cand;
      logic [NODE_W-1:0] at;
      int                pick;
      int                len;
      route_hop          hop;
      for (int i = 0; i < NODES; i++) begin
         best[i]   = '0;
         seen[i]   = 1'b0;
         done[i]   = 1'b0;
         linked[i] = 1'b0;
         via[i]    = '0;
      end
      seen[src] = 1'b1;
      forever begin
         pick = -1;
         for (int i = 0; i < NODES; i++) begin
            if (seen[i] && !done[i] && (pick < 0 || best[i] < best[pick]))
               pick = i;
         end
         if (pick < 0)
            break;
         done[pick] = 1'b1;
         for (int v = 0; v < NODES; v++) begin
            if (edge_on[pick * NODES + v]) begin
               cand = best[pick] + edge_len[pick * NODES + v];
               if (cand > DIST_MAX)
                  cand = DIST_MAX;   // saturate
               if (!seen[v] || cand[DIST_W-1:0] < best[v]) begin
                  seen[v]   = 1'b1;
                  best[v]   = cand[DIST_W-1:0];
                  via[v]    = pick[NODE_W-1:0];
                  linked[v] = 1'b1;
               end
            end
         end
      end
      if (!seen[dst]) begin
         // unreachable: single zero hop with last set
         hop = '{node: '0, reach: 1'b0, total: '0, last: 1'b1};
         pending_hops = {pending_hops, hop};
         return;
      end
      // walk back from the destination, then emit start first
      len = 0;
      at  = dst;
      forever begin
         trail[len] = at;
         len++;
         if (at == src || !linked[at] || len >= NODES)
            break;
         at = via[at];
      end
      for (int k = len - 1; k >= 0; k--) begin
         hop.node  = trail[k];
         hop.reach = 1'b1;
         hop.total = best[dst];
         hop.last  = (k == 0);
         pending_hops = {pending_hops, hop};
      end
   endtask

   // Drive one item, hold it until accepted, then update the shadow graph or
   // queue the expected route. Returns on the accepting edge with tvalid high.
   task automatic send_item(input op_type op, input logic [NODE_W-1:0] src,
                            input logic [NODE_W-1:0] dst, input logic [WEIGHT_W-1:0] weight,
                            input logic present);
      int gap;
      int idx;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, present, weight, dst, src};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (op == OP_QUERY) begin
         predict_route(src, dst);
      end else begin
         idx = int'(src) * NODES + int'(dst);
         if (present) begin
            edge_len[idx] = weight;
            edge_on[idx]  = 1'b1;
         end else begin
            edge_on[idx] = 1'b0;   // length left as is
         end
      end
   endtask

   // no edges yet: unreachable and start-equals-destination
   task automatic test_empty_graph();
      send_item(OP_QUERY, 3'd3, 3'd5, 16'hFFFF, 1'b1);
      send_item(OP_QUERY, 3'd7, 3'd7, 16'h0000, 1'b0);
      send_item(OP_QUERY, 3'd0, 3'd0, 16'h5A5A, 1'b1);
   endtask

   // full-scale and zero weights, one-way reachability
   task automatic test_weight_extremes();
      send_item(OP_LOAD,  3'd0, 3'd7, 16'hFFFF, 1'b1);
      send_item(OP_LOAD,  3'd7, 3'd6, 16'h0000, 1'b1);
      send_item(OP_QUERY, 3'd0, 3'd6, 16'h0000, 1'b0);
      send_item(OP_QUERY, 3'd6, 3'd0, 16'hFFFF, 1'b1);
   endtask

   // eight-node path, every hop at full weight
   task automatic test_long_chain();
      for (int i = 0; i < NODES - 1; i++)
         send_item(OP_LOAD, i[NODE_W-1:0], NODE_W'(i + 1), 16'hFFFF, 1'b1);
      send_item(OP_QUERY, 3'd0, 3'd7, 16'h0000, 1'b0);
   endtask

   // equal-distance pick goes to the lower node, equal relax keeps the old
   // predecessor; removing an edge reroutes
   task automatic test_tie_break();
      send_item(OP_LOAD,  3'd2, 3'd3, 16'd5, 1'b1);
      send_item(OP_LOAD,  3'd2, 3'd4, 16'd5, 1'b1);
      send_item(OP_LOAD,  3'd3, 3'd5, 16'd1, 1'b1);
      send_item(OP_LOAD,  3'd4, 3'd5, 16'd1, 1'b1);
      send_item(OP_QUERY, 3'd2, 3'd5, 16'd0, 1'b0);
      send_item(OP_LOAD,  3'd3, 3'd5, 16'hA5A5, 1'b0);
      send_item(OP_QUERY, 3'd2, 3'd5, 16'd0, 1'b0);
   endtask

   // rounds of graph edits followed by queries
   task automatic test_random_traffic(input int count);
      int target;
      int mode;
      int perm [NODES];
      int j;
      int tmp;
      int hops;
      int base;
      int hit;
      target = items_sent + count;
      while (items_sent < target) begin
         mode = $urandom_range(3);
         case (mode)
            0: begin
               // sparse random edges, full weight range
               repeat ($urandom_range(6, 2))
                  send_item(OP_LOAD, NODE_W'($urandom_range(7)), NODE_W'($urandom_range(7)),
                            WEIGHT_W'($urandom_range(65535)), $urandom_range(3) != 0);
            end
            1: begin
               // tiny weights so ties are common
               repeat ($urandom_range(8, 3))
                  send_item(OP_LOAD, NODE_W'($urandom_range(7)), NODE_W'($urandom_range(7)),
                            WEIGHT_W'($urandom_range(3)), 1'b1);
            end
            2: begin
               // chain through a shuffled node order, then query its ends
               for (int i = 0; i < NODES; i++)
                  perm[i] = i;
               for (int i = NODES - 1; i > 0; i--) begin
                  j       = $urandom_range(i);
                  tmp     = perm[i];
                  perm[i] = perm[j];
                  perm[j] = tmp;
               end
               hops = $urandom_range(NODES - 1, 2);
               for (int i = 0; i < hops; i++)
                  send_item(OP_LOAD, NODE_W'(perm[i]), NODE_W'(perm[i + 1]),
                            $urandom_range(1) ? 16'hFFFF : WEIGHT_W'($urandom_range(15)), 1'b1);
               send_item(OP_QUERY, NODE_W'(perm[0]), NODE_W'(perm[hops]),
                         WEIGHT_W'($urandom_range(65535)), 1'($urandom_range(1)));
            end
            default: begin
               // remove edges that exist, when any do
               repeat ($urandom_range(5, 2)) begin
                  base = $urandom_range(EDGES - 1);
                  hit  = base;
                  for (int k = 0; k < EDGES; k++) begin
                     if (edge_on[(base + k) % EDGES]) begin
                        hit = (base + k) % EDGES;
                        break;
                     end
                  end
                  send_item(OP_LOAD, NODE_W'(hit / NODES), NODE_W'(hit % NODES),
                            WEIGHT_W'($urandom_range(65535)), 1'b0);
               end
            end
         endcase
         repeat ($urandom_range(3, 1))
            send_item(OP_QUERY, NODE_W'($urandom_range(7)), NODE_W'($urandom_range(7)),
                      WEIGHT_W'($urandom_range(65535)), 1'($urandom_range(1)));
      end
   endtask

   // receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // result checker: each accepted item against the oldest expected hop
   always @(posedge clock) begin
      route_hop got;
      route_hop want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{node: rsp_tdata[2:0], reach: rsp_tdata[3], total: rsp_tdata[23:4],
                 last: rsp_tlast};
         if (pending_hops.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: node %0d reach %0d dist %0d last %0d",
                        got.node, got.reach, got.total, got.last);
         end else begin
            want = pending_hops.pop_front();
            if (got.node !== want.node || got.reach !== want.reach ||
                got.total !== want.total || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("hop mismatch: exp node %0d reach %0d dist %0d last %0d",
                           want.node, want.reach, want.total, want.last);
                  $display("              got node %0d reach %0d dist %0d last %0d",
                           got.node, got.reach, got.total, got.last);
               end
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < EDGES; i++) begin
         edge_len[i] = '0;
         edge_on[i]  = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // busy sender, heavy back-pressure
      send_idle_pct = 9;
      recv_idle_pct = 66;
      test_empty_graph();
      test_weight_extremes();
      test_long_chain();
      test_tie_break();
      test_random_traffic(100);

      // bursty sender, light back-pressure
      send_idle_pct = 66;
      recv_idle_pct = 9;
      test_random_traffic(100);

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(100);

      req_tvalid <= 1'b0;
      while (pending_hops.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatches == 0 && pending_hops.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
